/* hdl/wbc_pkg.sv */
// Package for the write-back set-associative cache unit.
// Holds the geometry constants and the controller/datapath structs.
// Depends on nothing.
`timescale 1ns / 1ps
package wbc_pkg;

  localparam int SETS       = 8;
  localparam int WAYS       = 4;
  localparam int LINE_WORDS = 16;
  localparam int MEM_BYTES  = 65536;

  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 32;
  localparam int STRB_W   = 4;
  localparam int OFF_W    = $clog2(LINE_WORDS);
  localparam int LINE_LSB = OFF_W + 2;
  localparam int SET_W    = $clog2(SETS);
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W    = ADDR_W - LINE_LSB - SET_W;
  localparam int CNT_W    = OFF_W + 1;
  localparam int MEM_WORDS   = MEM_BYTES / 4;
  localparam int MEM_AW      = $clog2(MEM_WORDS);
  localparam int CACHE_DEPTH = SETS * WAYS * LINE_WORDS;
  localparam int CACHE_AW    = SET_W + WAY_W + OFF_W;

  localparam logic CMD_STORE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              accept;
    logic              wb;
    logic              fill;
    logic              fill_done;
    logic              commit;
    logic              clr;
    logic [CNT_W-1:0]  cnt;
    logic [MEM_AW-1:0] clr_addr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
    logic victim_dirty;
    logic out_busy;
  } sts_t;

endpackage

/* hdl/wbc_if.sv */
// Valid/ready channel interfaces for the cache unit's request and result items.
// Depends on wbc_pkg.
`timescale 1ns / 1ps
interface wbc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [wbc_pkg::ADDR_W-1:0] address;
  logic [wbc_pkg::STRB_W-1:0] byte_strobe;
  logic [wbc_pkg::DATA_W-1:0] write_data;
  modport source (output valid, command, address, byte_strobe, write_data, input ready);
  modport sink (input valid, command, address, byte_strobe, write_data, output ready);
endinterface

interface wbc_out_if;
  logic                       valid;
  logic                       ready;
  logic [wbc_pkg::DATA_W-1:0] read_data;
  logic                       hit;
  logic                       wrote_back;
  modport source (output valid, read_data, hit, wrote_back, input ready);
  modport sink (input valid, read_data, hit, wrote_back, output ready);
endinterface

/* hdl/wbc_ram.sv */
// Generic simple dual-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module wbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/wbc_ctrl.sv */
// Controller state machine of the cache unit: clear pass, lookup, write-back,
// refill and result commit. Depends on wbc_pkg.
`timescale 1ns / 1ps
module wbc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  wbc_pkg::sts_t sts,
  output wbc_pkg::cmd_t cmd
);

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_WB     = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_ACCESS = 3'd4;
  localparam logic [2:0] S_MERGE  = 3'd5;

  localparam logic [wbc_pkg::CNT_W-1:0] CNT_END = wbc_pkg::CNT_W'(wbc_pkg::LINE_WORDS);
  localparam logic [wbc_pkg::MEM_AW-1:0] CLR_END = wbc_pkg::MEM_AW'(wbc_pkg::MEM_WORDS - 1);

  logic [2:0]                  state_r, state_nxt;
  logic [wbc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [wbc_pkg::MEM_AW-1:0]  clr_r, clr_nxt;
  logic                        accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_ready && in_valid;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    clr_nxt   = clr_r;
    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_END) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          if (sts.hit) begin
            state_nxt = S_MERGE;
          end else if (sts.victim_dirty) begin
            state_nxt = S_WB;
          end else begin
            state_nxt = S_FILL;
          end
        end
      end
      S_WB: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_END) begin
          cnt_nxt   = '0;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_END) begin
          state_nxt = S_ACCESS;
        end
      end
      S_ACCESS: begin
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        if (!sts.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_comb begin
    cmd.accept    = accept;
    cmd.wb        = (state_r == S_WB);
    cmd.fill      = (state_r == S_FILL);
    cmd.fill_done = (state_r == S_FILL) && (cnt_r == CNT_END);
    cmd.commit    = (state_r == S_MERGE) && !sts.out_busy;
    cmd.clr       = (state_r == S_CLR);
    cmd.cnt       = cnt_r;
    cmd.clr_addr  = clr_r;
  end

endmodule

/* hdl/wbc_dp.sv */
// Datapath of the cache unit: tag/valid/dirty arrays, victim pointers, line
// and backing RAMs, byte merge and result register. Depends on wbc_pkg, wbc_ram.
`timescale 1ns / 1ps
module wbc_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wbc_pkg::cmd_t              cmd,
  output wbc_pkg::sts_t              sts,
  input  logic                       in_command,
  input  logic [wbc_pkg::ADDR_W-1:0] in_address,
  input  logic [wbc_pkg::STRB_W-1:0] in_byte_strobe,
  input  logic [wbc_pkg::DATA_W-1:0] in_write_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [wbc_pkg::DATA_W-1:0] out_read_data,
  output logic                       out_hit,
  output logic                       out_wrote_back
);

  logic [wbc_pkg::TAG_W-1:0] tag_r   [wbc_pkg::SETS][wbc_pkg::WAYS];
  logic                      valid_r [wbc_pkg::SETS][wbc_pkg::WAYS];
  logic                      dirty_r [wbc_pkg::SETS][wbc_pkg::WAYS];
  logic [wbc_pkg::WAY_W-1:0] ptr_r   [wbc_pkg::SETS];

  logic [wbc_pkg::SET_W-1:0] in_set;
  logic [wbc_pkg::TAG_W-1:0] in_tag;
  logic [wbc_pkg::OFF_W-1:0] in_off;
  logic                      lk_hit;
  logic [wbc_pkg::WAY_W-1:0] lk_way, lk_victim;

  logic                       cmd_r;
  logic [wbc_pkg::TAG_W-1:0]  rtag_r, otag_r;
  logic [wbc_pkg::SET_W-1:0]  set_r;
  logic [wbc_pkg::OFF_W-1:0]  off_r;
  logic [wbc_pkg::STRB_W-1:0] strb_r;
  logic [wbc_pkg::DATA_W-1:0] wdata_r;
  logic [wbc_pkg::WAY_W-1:0]  way_r;
  logic                       hit_r, wb_r;

  logic [wbc_pkg::OFF_W-1:0]    idx, idx_m1;
  logic                         cnt_nz;
  logic [wbc_pkg::CACHE_AW-1:0] c_rd_addr, c_wr_addr;
  logic                         c_wr_en;
  logic [wbc_pkg::DATA_W-1:0]   c_wr_data, c_rd_data;
  logic [wbc_pkg::MEM_AW-1:0]   m_rd_addr, m_wr_addr;
  logic                         m_wr_en;
  logic [wbc_pkg::DATA_W-1:0]   m_wr_data, m_rd_data;
  logic [wbc_pkg::DATA_W-1:0]   mask, merged;
  logic                         out_valid_r;
  logic [wbc_pkg::DATA_W-1:0]   rdata_r;
  logic                         ohit_r, owb_r;

  assign in_off = in_address[2 +: wbc_pkg::OFF_W];
  assign in_set = in_address[wbc_pkg::LINE_LSB +: wbc_pkg::SET_W];
  assign in_tag = in_address[wbc_pkg::LINE_LSB + wbc_pkg::SET_W +: wbc_pkg::TAG_W];

  // Lowest matching way wins, as only one can match in practice.
  always_comb begin
    lk_hit = 1'b0;
    lk_way = '0;
    for (int w = wbc_pkg::WAYS - 1; w >= 0; w--) begin
      if (valid_r[in_set][w] && (tag_r[in_set][w] == in_tag)) begin
        lk_hit = 1'b1;
        lk_way = wbc_pkg::WAY_W'(w);
      end
    end
    lk_victim = ptr_r[in_set];
  end

  assign sts.hit          = lk_hit;
  assign sts.victim_dirty = dirty_r[in_set][lk_victim];
  assign sts.out_busy     = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r   <= in_command;
      rtag_r  <= in_tag;
      set_r   <= in_set;
      off_r   <= in_off;
      strb_r  <= in_byte_strobe;
      wdata_r <= in_write_data;
      hit_r   <= lk_hit;
      way_r   <= lk_hit ? lk_way : lk_victim;
      otag_r  <= tag_r[in_set][lk_victim];
      wb_r    <= !lk_hit && dirty_r[in_set][lk_victim];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < wbc_pkg::SETS; s++) begin
        ptr_r[s] <= '0;
        for (int w = 0; w < wbc_pkg::WAYS; w++) begin
          tag_r[s][w]   <= '0;
          valid_r[s][w] <= 1'b0;
          dirty_r[s][w] <= 1'b0;
        end
      end
    end else begin
      if (cmd.fill_done) begin
        tag_r[set_r][way_r]   <= rtag_r;
        valid_r[set_r][way_r] <= 1'b1;
        dirty_r[set_r][way_r] <= 1'b0;
        ptr_r[set_r] <= (way_r == wbc_pkg::WAY_W'(wbc_pkg::WAYS - 1)) ? '0 : way_r + 1'b1;
      end
      if (cmd.commit && (cmd_r == wbc_pkg::CMD_STORE)) begin
        dirty_r[set_r][way_r] <= 1'b1;
      end
    end
  end

  assign idx    = cmd.cnt[wbc_pkg::OFF_W-1:0];
  assign idx_m1 = wbc_pkg::OFF_W'(cmd.cnt - 1'b1);
  assign cnt_nz = (cmd.cnt != '0);

  always_comb begin
    mask = '0;
    for (int b = 0; b < wbc_pkg::STRB_W; b++) begin
      mask[8*b +: 8] = {8{strb_r[b]}};
    end
    merged = (cmd_r == wbc_pkg::CMD_STORE) ? ((wdata_r & mask) | (c_rd_data & ~mask)) :
                                             c_rd_data;
  end

  always_comb begin
    if (cmd.accept) begin
      c_rd_addr = {in_set, lk_way, in_off};
    end else if (cmd.wb) begin
      c_rd_addr = {set_r, way_r, idx};
    end else begin
      c_rd_addr = {set_r, way_r, off_r};
    end
    if (cmd.fill) begin
      c_wr_en   = cnt_nz;
      c_wr_addr = {set_r, way_r, idx_m1};
      c_wr_data = m_rd_data;
    end else begin
      c_wr_en   = cmd.commit && (cmd_r == wbc_pkg::CMD_STORE);
      c_wr_addr = {set_r, way_r, off_r};
      c_wr_data = merged;
    end
    m_rd_addr = wbc_pkg::MEM_AW'({rtag_r, set_r, idx});
    if (cmd.clr) begin
      m_wr_en   = 1'b1;
      m_wr_addr = cmd.clr_addr;
      m_wr_data = '0;
    end else begin
      m_wr_en   = cmd.wb && cnt_nz;
      m_wr_addr = wbc_pkg::MEM_AW'({otag_r, set_r, idx_m1});
      m_wr_data = c_rd_data;
    end
  end

  wbc_ram #(.WIDTH(wbc_pkg::DATA_W), .DEPTH(wbc_pkg::CACHE_DEPTH)) u_line_ram (
    .clk     (clk),
    .wr_en   (c_wr_en),
    .wr_addr (c_wr_addr),
    .wr_data (c_wr_data),
    .rd_addr (c_rd_addr),
    .rd_data (c_rd_data)
  );

  wbc_ram #(.WIDTH(wbc_pkg::DATA_W), .DEPTH(wbc_pkg::MEM_WORDS)) u_mem_ram (
    .clk     (clk),
    .wr_en   (m_wr_en),
    .wr_addr (m_wr_addr),
    .wr_data (m_wr_data),
    .rd_addr (m_rd_addr),
    .rd_data (m_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rdata_r <= merged;
      ohit_r  <= hit_r;
      owb_r   <= wb_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = rdata_r;
  assign out_hit        = ohit_r;
  assign out_wrote_back = owb_r;

endmodule

/* hdl/write_back_set_assoc_cache_unit.sv */
// Top level of the write-back, write-allocate set-associative cache unit.
// Depends on wbc_pkg, wbc_if, wbc_ctrl and wbc_dp.
`timescale 1ns / 1ps
//
//   Channel  Direction  Handshake      Contents
//   in_ch    sink       valid/ready    command, address, byte_strobe, write_data
//   out_ch   source     valid/ready    read_data, hit, wrote_back
//
// A hit does the tag compare and line RAM read in the accept cycle, then the
// merge and result register load.
// A clean miss refills the 16-word line through the single backing RAM read
// port; a dirty miss first writes the victim line back.
// After reset a clearing pass zeroes all 16384 words of the backing memory,
// one word a cycle, while in_ch.ready stays low.
// A stalled result holds in the output register; the unit waits in its merge
// step until that register is free and takes one item at a time.
module write_back_set_assoc_cache_unit (
  input  logic      clk,
  input  logic      rst_n,
  wbc_in_if.sink    in_ch,
  wbc_out_if.source out_ch
);

  wbc_pkg::cmd_t cmd;
  wbc_pkg::sts_t sts;

  // The controller sequences each item; the datapath owns all storage.
  wbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wbc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_command     (in_ch.command),
    .in_address     (in_ch.address),
    .in_byte_strobe (in_ch.byte_strobe),
    .in_write_data  (in_ch.write_data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_read_data  (out_ch.read_data),
    .out_hit        (out_ch.hit),
    .out_wrote_back (out_ch.wrote_back)
  );

endmodule

/* hdl/wbc_checker.sv */
// Port-level checker for the cache unit, bound to the top level.
// Depends on wbc_pkg and write_back_set_assoc_cache_unit.
`timescale 1ns / 1ps
module wbc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [wbc_pkg::DATA_W-1:0] out_read_data,
  input logic                       out_hit,
  input logic                       out_wrote_back
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_read_data)))
    else $error("result changed while stalled");

  // The clearing pass keeps the input closed right after reset.
  a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("input open during clearing pass");

  // One item at a time: the unit is busy the cycle after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input open right after accept");

  // A hit never writes back.
  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_wrote_back))
    else $error("hit reported with write-back");

endmodule

bind write_back_set_assoc_cache_unit wbc_checker u_wbc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_read_data  (out_ch.read_data),
  .out_hit        (out_ch.hit),
  .out_wrote_back (out_ch.wrote_back)
);
